/* src/rms_pkg.sv */
package rms_pkg;

	typedef enum logic [2:0] {
		MODE_BOOT    = 3'd0,
		MODE_BALANCE = 3'd1,
		MODE_SIT     = 3'd2,
		MODE_JUMP    = 3'd3,
		MODE_KPLACE  = 3'd4,
		MODE_KRUN    = 3'd5,
		MODE_CALIB   = 3'd6,
		MODE_STOP    = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		REQ_NONE         = 4'd0,
		REQ_STOP         = 4'd1,
		REQ_BOOT         = 4'd2,
		REQ_BOOT_CONFIRM = 4'd3,
		REQ_DONE         = 4'd4,
		REQ_RESET_BAL    = 4'd5,
		REQ_SIT          = 4'd6,
		REQ_CALIB        = 4'd7,
		REQ_JUMP_PLACE   = 4'd8,
		REQ_JUMP_FWD     = 4'd9,
		REQ_JUMP_BACK    = 4'd10,
		REQ_JUMP_LEFT    = 4'd11,
		REQ_JUMP_RIGHT   = 4'd12,
		REQ_KPLACE       = 4'd13,
		REQ_KRUN         = 4'd14
	} req_t;

	typedef struct packed {
		logic [3:0] operator_request;
		logic [3:0] action_report;
		logic       calibrate_flag;
		logic       batt_valid;
		logic       batt_low;
	} in_item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       mode_entered;
		logic [2:0] jump_direction;
		logic       exit_locked;
		logic       stop_forced;
	} out_item_t;

endpackage

/* src/rms_if.sv */
interface rms_in_if;
	logic               valid;
	logic               ready;
	rms_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rms_out_if;
	logic               valid;
	logic               ready;
	rms_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/rms_step.sv */
module rms_step (
	input  rms_pkg::in_item_t  item,
	input  rms_pkg::mode_t     cur_mode,
	input  logic               cur_lock,
	output rms_pkg::out_item_t result
);

	logic            lock_nxt;
	rms_pkg::mode_t  mode_nxt;
	logic            entered;
	logic [2:0]      jdir;
	logic            forced;
	rms_pkg::req_t   op;
	rms_pkg::req_t   r;
	logic [3:0]      jump_ofs;

	assign op = rms_pkg::req_t'(item.operator_request);
	assign jump_ofs = item.operator_request - 4'(rms_pkg::REQ_JUMP_PLACE);

	always_comb begin
		lock_nxt = cur_lock;
		if (item.batt_valid && !item.batt_low) begin
			lock_nxt = 1'b0;
		end else if ((cur_mode == rms_pkg::MODE_SIT || cur_mode == rms_pkg::MODE_CALIB) &&
				item.batt_valid && item.batt_low) begin
			lock_nxt = 1'b1;
		end
	end

	always_comb begin
		if (cur_mode == rms_pkg::MODE_BALANCE) begin
			r = item.calibrate_flag ? rms_pkg::REQ_CALIB : op;
		end else if (cur_mode == rms_pkg::MODE_STOP) begin
			r = op;
		end else begin
			r = rms_pkg::req_t'(item.action_report);
		end
	end

	always_comb begin
		mode_nxt = cur_mode;
		entered  = 1'b0;
		jdir     = 3'd0;
		forced   = 1'b0;
		if (cur_mode != rms_pkg::MODE_STOP && op == rms_pkg::REQ_STOP) begin
			mode_nxt = rms_pkg::MODE_STOP;
			entered  = 1'b1;
			forced   = 1'b1;
		end else if (r == rms_pkg::REQ_NONE) begin
			mode_nxt = cur_mode;
		end else if (cur_mode != rms_pkg::MODE_STOP && r == rms_pkg::REQ_STOP) begin
			mode_nxt = rms_pkg::MODE_STOP;
			entered  = 1'b1;
		end else begin
			case (cur_mode)
				rms_pkg::MODE_BOOT: begin
					if (r == rms_pkg::REQ_DONE) begin
						mode_nxt = rms_pkg::MODE_BALANCE;
						entered  = 1'b1;
					end
				end
				rms_pkg::MODE_BALANCE: begin
					case (r)
						rms_pkg::REQ_RESET_BAL: begin
							mode_nxt = rms_pkg::MODE_BALANCE;
							entered  = 1'b1;
						end
						rms_pkg::REQ_SIT: begin
							mode_nxt = rms_pkg::MODE_SIT;
							entered  = 1'b1;
						end
						rms_pkg::REQ_CALIB: begin
							mode_nxt = rms_pkg::MODE_CALIB;
							entered  = 1'b1;
						end
						rms_pkg::REQ_JUMP_PLACE, rms_pkg::REQ_JUMP_FWD,
						rms_pkg::REQ_JUMP_BACK, rms_pkg::REQ_JUMP_LEFT,
						rms_pkg::REQ_JUMP_RIGHT: begin
							mode_nxt = rms_pkg::MODE_JUMP;
							entered  = 1'b1;
							jdir     = jump_ofs[2:0];
						end
						rms_pkg::REQ_KPLACE: begin
							mode_nxt = rms_pkg::MODE_KPLACE;
							entered  = 1'b1;
						end
						rms_pkg::REQ_KRUN: begin
							mode_nxt = rms_pkg::MODE_KRUN;
							entered  = 1'b1;
						end
						default: begin
							mode_nxt = cur_mode;
						end
					endcase
				end
				rms_pkg::MODE_SIT: begin
					if (r == rms_pkg::REQ_CALIB) begin
						mode_nxt = rms_pkg::MODE_CALIB;
						entered  = 1'b1;
					end else if (r == rms_pkg::REQ_DONE && !lock_nxt) begin
						mode_nxt = rms_pkg::MODE_BALANCE;
						entered  = 1'b1;
					end
				end
				rms_pkg::MODE_CALIB: begin
					if (r == rms_pkg::REQ_DONE && !lock_nxt) begin
						mode_nxt = rms_pkg::MODE_BALANCE;
						entered  = 1'b1;
					end
				end
				rms_pkg::MODE_JUMP: begin
					if (r == rms_pkg::REQ_DONE) begin
						mode_nxt = rms_pkg::MODE_BALANCE;
						entered  = 1'b1;
					end
				end
				rms_pkg::MODE_KPLACE: begin
					if (r == rms_pkg::REQ_KRUN) begin
						mode_nxt = rms_pkg::MODE_KRUN;
						entered  = 1'b1;
					end else if (r == rms_pkg::REQ_DONE) begin
						mode_nxt = rms_pkg::MODE_BALANCE;
						entered  = 1'b1;
					end
				end
				rms_pkg::MODE_KRUN: begin
					if (r == rms_pkg::REQ_KPLACE) begin
						mode_nxt = rms_pkg::MODE_KPLACE;
						entered  = 1'b1;
					end else if (r == rms_pkg::REQ_DONE) begin
						mode_nxt = rms_pkg::MODE_BALANCE;
						entered  = 1'b1;
					end
				end
				default: begin
					if (r == rms_pkg::REQ_BOOT && !lock_nxt) begin
						mode_nxt = rms_pkg::MODE_BOOT;
						entered  = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		result.mode           = mode_nxt;
		result.mode_entered   = entered;
		result.jump_direction = jdir;
		result.exit_locked    = lock_nxt;
		result.stop_forced    = forced;
	end

endmodule

/* src/robot_mode_supervisor.sv */
// A beat accepted into the input register moves through the step into the result register,
// two register stages (input register, then result register) in total; a stall holds it.
// One beat per cycle while results are taken; the mode and lock registers update with each step.
// Reset (arst_n low, asynchronous): mode returns to boot, the exit lock clears,
// and both pipeline stages empty.
module robot_mode_supervisor (
	input  logic        clk,
	input  logic        arst_n,
	rms_in_if.sink      cmd,
	rms_out_if.source   res
);

	logic               valid_s1;
	rms_pkg::in_item_t  item_s1;
	logic               valid_s2;
	rms_pkg::out_item_t item_s2;
	rms_pkg::mode_t     mode_q;
	logic               lock_q;
	logic               adv;
	rms_pkg::out_item_t step_res;

	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign res.valid = valid_s2;
	assign res.data  = item_s2;

	rms_step u_step (
		.item     (item_s1),
		.cur_mode (mode_q),
		.cur_lock (lock_q),
		.result   (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= rms_pkg::MODE_BOOT;
			lock_q   <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				mode_q   <= rms_pkg::mode_t'(step_res.mode);
				lock_q   <= step_res.exit_locked;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
		if (adv) begin
			item_s2 <= step_res;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.jump_direction != 3'd0 |->
		item_s2.mode == 3'(rms_pkg::MODE_JUMP) && item_s2.mode_entered)
	else $error("Jump direction set without entry to jump.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.stop_forced |->
		item_s2.mode == 3'(rms_pkg::MODE_STOP) && item_s2.mode_entered)
	else $error("Forced stop without entry to stop.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(mode_q) && $stable(lock_q))
	else $error("Supervisor state changed without a step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> lock_q == item_s2.exit_locked && mode_q == rms_pkg::mode_t'(item_s2.mode))
	else $error("Result does not match the stored state.");

endmodule
